// ----- rtl/core/rlms_pkg.sv -----
// ----------------------------------------------------------------------------
// rlms_pkg
// Shared types, constants and tables of the radial light map shader.
// ----------------------------------------------------------------------------
package rlms_pkg;

  localparam int MAP_WIDTH_DEF  = 80;
  localparam int MAP_HEIGHT_DEF = 64;
  localparam int LEVEL_W        = 9;
  localparam logic [8:0] LEVEL_MAX = 9'h100;

  localparam logic [1:0] KIND_CLEAR = 2'd0;
  localparam logic [1:0] KIND_LIGHT = 2'd1;
  localparam logic [1:0] KIND_SHADE = 2'd2;

  localparam logic [2:0] REG_ENABLE = 3'd0;
  localparam logic [2:0] REG_LEFT   = 3'd1;
  localparam logic [2:0] REG_TOP    = 3'd2;
  localparam logic [2:0] REG_RIGHT  = 3'd3;
  localparam logic [2:0] REG_BOTTOM = 3'd4;

  // one command as it travels from the front to the back
  typedef struct packed {
    logic [1:0]  kind;
    logic [8:0]  pos_x;
    logic [8:0]  pos_y;
    logic [7:0]  radius;
    logic [3:0]  power;
    logic [3:0]  fill_level;
    logic [15:0] pixel_color;
  } cmd_t;

  // clip region and enable
  typedef struct packed {
    logic       enable;
    logic [6:0] left;
    logic [5:0] top;
    logic [6:0] right;
    logic [5:0] bottom;
  } cfg_t;

  function automatic logic [8:0] level_lut(input logic [3:0] i);
    logic [8:0] v;
    case (i)
      4'd0:  v = 9'h000;
      4'd1:  v = 9'h018;
      4'd2:  v = 9'h028;
      4'd3:  v = 9'h038;
      4'd4:  v = 9'h048;
      4'd5:  v = 9'h060;
      4'd6:  v = 9'h070;
      4'd7:  v = 9'h080;
      4'd8:  v = 9'h0a0;
      4'd9:  v = 9'h0b0;
      4'd10: v = 9'h0d0;
      4'd11: v = 9'h0e0;
      4'd12: v = 9'h0e8;
      4'd13: v = 9'h0f0;
      4'd14: v = 9'h0f8;
      default: v = 9'h100;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/core/rlms_ram.sv -----
// ----------------------------------------------------------------------------
// rlms_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module rlms_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 5120
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// ----- rtl/core/rlms_front.sv -----
// ----------------------------------------------------------------------------
// rlms_front
// Input side: accepts items, drops unknown kinds, and holds a two-entry queue.
// ----------------------------------------------------------------------------
module rlms_front
  import rlms_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  cmd_t in_cmd,
  output logic q_valid,
  input  logic q_ready,
  output cmd_t q_cmd
);
  cmd_t       slot [2];
  logic       rd_ptr, wr_ptr;
  logic [1:0] count;
  logic       push, pop;

  assign in_ready = (count != 2'd2);
  // kind 3 is accepted and discarded
  assign push     = in_valid && in_ready && (in_cmd.kind != 2'd3);
  assign q_valid  = (count != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_cmd    = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= in_cmd;
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// ----- rtl/core/rlms_back.sv -----
// ----------------------------------------------------------------------------
// rlms_back
// Execution side: sequencer for clear, light and shade over the map memory.
// ----------------------------------------------------------------------------
module rlms_back
  import rlms_pkg::*;
#(
  parameter int MAP_WIDTH  = MAP_WIDTH_DEF,
  parameter int MAP_HEIGHT = MAP_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        q_valid,
  output logic        q_ready,
  input  cmd_t        q_cmd,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] shaded_color,
  output logic        busy
);
  localparam int DEPTH = MAP_WIDTH * MAP_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int XW    = $clog2(MAP_WIDTH);
  localparam int YW    = $clog2(MAP_HEIGHT);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_INIT   = 10'b0000000010,
    S_FILL   = 10'b0000000100,
    S_DIV    = 10'b0000001000,
    S_LRD    = 10'b0000010000,
    S_LDIST  = 10'b0000100000,
    S_LMUL   = 10'b0001000000,
    S_LWR    = 10'b0010000000,
    S_SRD    = 10'b0100000000,
    S_SOUT   = 10'b1000000000
  } state_t;

  state_t state;
  cmd_t   cmd;

  // scan window and cursor, signed 11-bit to cover centre +- radius
  logic signed [10:0] x0, x1, y1, tx, ty;
  logic        [AW-1:0] addr, fill_addr;
  logic        [8:0]  fill_val;
  // restoring divider for power*256/radius
  logic [11:0] div_q;
  logic [8:0]  div_r;
  logic [3:0]  div_n;
  logic [11:0] decay;
  logic [8:0]  odist;
  logic [3:0]  p_idx;
  logic [15:0] color_q;

  logic        we;
  logic [AW-1:0] ram_addr;
  logic [8:0]  wdata, rdata;

  rlms_ram #(.WIDTH(LEVEL_W), .DEPTH(DEPTH)) u_map (
    .clk(clk), .we(we), .addr(ram_addr), .wdata(wdata), .rdata(rdata)
  );

  // absolute offsets from the centre
  logic signed [10:0] cx, cy, ddx, ddy;
  logic [9:0] ax, ay, lo, hi;
  logic [20:0] dsum;
  assign cx  = 11'(signed'(cmd.pos_x));
  assign cy  = 11'(signed'(cmd.pos_y));
  assign ddx = tx - cx;
  assign ddy = ty - cy;
  assign ax  = ddx[10] ? 10'(-ddx) : 10'(ddx);
  assign ay  = ddy[10] ? 10'(-ddy) : 10'(ddy);
  assign lo  = (ax < ay) ? ax : ay;
  assign hi  = (ax < ay) ? ay : ax;
  assign dsum = 21'(hi) * 21'd1007 + 21'(lo) * 21'd441
              - (({11'd0, hi} < ({11'd0, lo} << 4)) ? 21'(hi) * 21'd40 : 21'd0)
              + 21'd512;

  // drop and level index
  logic [20:0] drop;
  assign drop = (21'(odist) * 21'(decay)) >> 8;

  // clipped window bounds
  logic signed [10:0] rad11, wx0, wx1, wy0, wy1, cl, ct, cr, cb;
  assign rad11 = 11'(q_cmd.radius);
  assign cl = 11'(cfg.left);
  assign ct = 11'(cfg.top);
  assign cr = 11'(cfg.right);
  assign cb = 11'(cfg.bottom);
  assign wx0 = 11'(signed'(q_cmd.pos_x)) - rad11;
  assign wx1 = 11'(signed'(q_cmd.pos_x)) + rad11;
  assign wy0 = 11'(signed'(q_cmd.pos_y)) - rad11;
  assign wy1 = 11'(signed'(q_cmd.pos_y)) + rad11;

  // shade checks
  logic signed [10:0] sx, sy;
  logic shade_in;
  logic [AW-1:0] sidx;
  assign sx = 11'(signed'(q_cmd.pos_x));
  assign sy = 11'(signed'(q_cmd.pos_y));
  assign shade_in = cfg.enable && sx >= cl && sx <= cr && sy >= ct && sy <= cb
                 && sx >= 0 && sx < 11'(MAP_WIDTH) && sy >= 0 && sy < 11'(MAP_HEIGHT);
  assign sidx = AW'(sx[XW-1:0]) + AW'(MAP_WIDTH) * AW'(sy[YW-1:0]);

  logic inmap;
  assign inmap = tx >= 0 && tx < 11'(MAP_WIDTH) && ty >= 0 && ty < 11'(MAP_HEIGHT);

  logic [AW-1:0] tidx;
  assign tidx = AW'(tx[XW-1:0]) + AW'(MAP_WIDTH) * AW'(ty[YW-1:0]);

  // take a command only when idle and no result is stuck
  assign q_ready = (state == S_IDLE) && !(out_valid && !out_ready);
  assign busy    = (state != S_IDLE);

  // a result is raised by a passed-through pixel or the shade output step
  logic out_set;
  assign out_set = (state == S_SOUT) ||
                   (q_valid && q_ready && q_cmd.kind == KIND_SHADE && !shade_in);

  // memory port selection
  logic [9:0] sum;
  assign sum = {1'b0, rdata} + {1'b0, level_lut(p_idx)};
  always_comb begin
    we       = 1'b0;
    wdata    = fill_val;
    ram_addr = addr;
    case (state)
      S_INIT, S_FILL: begin
        we = 1'b1;
        ram_addr = fill_addr;
      end
      S_LWR: begin
        we    = 1'b1;
        wdata = (sum > 10'(LEVEL_MAX)) ? LEVEL_MAX : sum[8:0];
      end
      default: ;
    endcase
  end

  // shaded channels
  logic [24:0] rr, gg, bb;
  assign rr = (25'(color_q & 16'hf800) * 25'(rdata)) >> 8;
  assign gg = (25'(color_q & 16'h07e0) * 25'(rdata)) >> 8;
  assign bb = (25'(color_q & 16'h001f) * 25'(rdata)) >> 8;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      fill_addr <= '0;
      fill_val  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_set) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (q_valid && !(out_valid && !out_ready)) begin
          cmd     <= q_cmd;
          color_q <= q_cmd.pixel_color;
          case (q_cmd.kind)
            KIND_CLEAR: begin
              fill_val  <= level_lut(q_cmd.fill_level);
              fill_addr <= '0;
              state     <= S_FILL;
            end
            KIND_LIGHT: begin
              if (q_cmd.radius != 8'd0 && !(wx1 < cl || wy1 < ct || wx0 > cr || wy0 > cb))
              begin
                x0    <= (wx0 < cl) ? cl : wx0;
                x1    <= (wx1 > cr) ? cr : wx1;
                y1    <= (wy1 > cb) ? cb : wy1;
                tx    <= (wx0 < cl) ? cl : wx0;
                ty    <= (wy0 < ct) ? ct : wy0;
                div_q <= {q_cmd.power, 8'd0};
                div_r <= '0;
                div_n <= 4'd0;
                state <= S_DIV;
              end
            end
            default: begin
              if (shade_in) begin
                addr  <= sidx;
                state <= S_SRD;
              end else begin
                shaded_color <= q_cmd.pixel_color;
              end
            end
          endcase
        end
        S_INIT, S_FILL: begin
          fill_addr <= fill_addr + AW'(1);
          if (fill_addr == AW'(DEPTH - 1)) state <= S_IDLE;
        end
        S_DIV: begin
          // one quotient bit a cycle
          logic [9:0] tr;
          tr = {div_r, div_q[11]};
          if (tr >= 10'(cmd.radius)) begin
            div_r <= 9'(tr - 10'(cmd.radius));
            div_q <= {div_q[10:0], 1'b1};
          end else begin
            div_r <= tr[8:0];
            div_q <= {div_q[10:0], 1'b0};
          end
          div_n <= div_n + 4'd1;
          if (div_n == 4'd11) state <= S_LRD;
        end
        S_LRD: begin
          if (div_n == 4'd12) begin
            decay <= div_q;
            div_n <= 4'd0;
          end
          if (inmap) begin
            addr  <= tidx;
            odist <= 9'(dsum >> 10);
            state <= S_LMUL;
          end else state <= S_LDIST;
        end
        S_LMUL: begin
          p_idx <= (drop >= 21'(cmd.power)) ? 4'd0 : 4'(21'(cmd.power) - drop);
          state <= S_LWR;
        end
        S_LWR, S_LDIST: begin
          if (tx == x1) begin
            tx <= x0;
            ty <= ty + 11'sd1;
            state <= (ty == y1) ? S_IDLE : S_LRD;
          end else begin
            tx <= tx + 11'sd1;
            state <= S_LRD;
          end
        end
        S_SRD: state <= S_SOUT;
        S_SOUT: begin
          shaded_color <= (rr[15:0] & 16'hf800) | (gg[15:0] & 16'h07e0)
                        | (bb[15:0] & 16'h001f);
          state        <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // the sequencer never takes an item while a result is stuck
  a_no_take: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && q_valid && out_valid && !out_ready) |=> state == S_IDLE)
    else $error("item taken while output stalled");
  // a finished result stays until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(shaded_color))
    else $error("result lost");
  // shade read is always followed by its output step
  a_shade: assert property (@(posedge clk) disable iff (rst)
    state == S_SRD |=> state == S_SOUT)
    else $error("shade sequence broken");
`endif
endmodule

// ----- rtl/core/radial_light_map_shader.sv -----
// ----------------------------------------------------------------------------
// radial_light_map_shader
// Per-pixel light map with clear, radial light and RGB565 shade items.
// ----------------------------------------------------------------------------
// channel  direction  handshake          payload
// in       input      in_valid/in_ready  kind pos_x pos_y radius power ...
// out      output     out_valid/ready    shaded_color
// cfg      input      APB psel/penable   enable, clip rectangle
//
// A shade item is passed through or read from the map. A clear item writes
// every map entry; a light item runs the decay division, then skips each
// off-map entry of its square and reads, scales and writes each other one.
// After reset the map is cleared, all MAP_WIDTH*MAP_HEIGHT entries (5120 by
// default), before the first item runs. A two-item queue parts input from
// the map sequencer, which waits in idle while a finished pixel is not taken.
// ----------------------------------------------------------------------------
module radial_light_map_shader
  import rlms_pkg::*;
#(
  parameter int MAP_WIDTH  = MAP_WIDTH_DEF,
  parameter int MAP_HEIGHT = MAP_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic signed [8:0] pos_x,
  input  logic signed [8:0] pos_y,
  input  logic [7:0]  radius,
  input  logic [3:0]  power,
  input  logic [3:0]  fill_level,
  input  logic [15:0] pixel_color,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] shaded_color
);
  cfg_t cfg;
  cmd_t in_cmd, q_cmd;
  logic q_valid, q_ready, busy;
  logic [2:0] ridx;

  assign pready = 1'b1;
  assign ridx   = paddr[4:2];

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{enable: 1'b1, left: 7'd0, top: 6'd0, right: 7'd79, bottom: 6'd63};
    end else if (psel && penable && pwrite) begin
      case (ridx)
        REG_ENABLE: cfg.enable <= pwdata[0];
        REG_LEFT:   cfg.left   <= pwdata[6:0];
        REG_TOP:    cfg.top    <= pwdata[5:0];
        REG_RIGHT:  cfg.right  <= pwdata[6:0];
        REG_BOTTOM: cfg.bottom <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_ENABLE: prdata = {31'd0, cfg.enable};
      REG_LEFT:   prdata = {25'd0, cfg.left};
      REG_TOP:    prdata = {26'd0, cfg.top};
      REG_RIGHT:  prdata = {25'd0, cfg.right};
      REG_BOTTOM: prdata = {26'd0, cfg.bottom};
      default:    prdata = 32'd0;
    endcase
  end

  assign in_cmd = '{kind: kind, pos_x: pos_x, pos_y: pos_y, radius: radius,
                    power: power, fill_level: fill_level, pixel_color: pixel_color};

  rlms_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_cmd(in_cmd),
    .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
  );

  rlms_back #(.MAP_WIDTH(MAP_WIDTH), .MAP_HEIGHT(MAP_HEIGHT)) u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .q_valid(q_valid), .q_ready(q_ready),
    .q_cmd(q_cmd), .out_valid(out_valid), .out_ready(out_ready),
    .shaded_color(shaded_color), .busy(busy)
  );

`ifndef SYNTHESIS
  // queue never fills while the sequencer is idle and nothing is waiting
  a_flow: assert property (@(posedge clk) disable iff (rst)
    (!busy && !q_valid) |-> in_ready)
    else $error("input blocked with empty queue");
`endif
endmodule

// ----- tb/sv/radial_light_map_shader_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// radial_light_map_shader_tb
// Drives clear, light and shade items with random gaps on both channels and
// checks every shaded pixel against a light map kept alongside the block.
// ----------------------------------------------------------------------------
module radial_light_map_shader_tb;
  import rlms_pkg::*;

  localparam int MW = 80;
  localparam int MH = 64;
  localparam int WATCHDOG_CYCLES = 400000;
  localparam logic [15:0] NO_CHECK = 16'h0000;

  logic        clk;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;
  logic        in_valid, in_ready;
  logic [1:0]  kind;
  logic signed [8:0] pos_x, pos_y;
  logic [7:0]  radius;
  logic [3:0]  power, fill_level;
  logic [15:0] pixel_color;
  logic        out_valid, out_ready;
  logic [15:0] shaded_color;

  radial_light_map_shader dut (.*);

  // model state
  logic [8:0]  lmap [MW*MH];
  cfg_t        shade_cfg;
  logic [15:0] pixel_q [$];
  int          n_err;
  int          idle_cycles;
  bit          stim_done;

  // directed rows: item, and a typed-in expectation where obvious
  typedef struct {
    cmd_t        c;
    bit          typed;
    logic [15:0] want;
  } row_t;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [8:0] lvl(input logic [3:0] i);
    logic [8:0] t [16] = '{9'h000, 9'h018, 9'h028, 9'h038, 9'h048, 9'h060,
                           9'h070, 9'h080, 9'h0a0, 9'h0b0, 9'h0d0, 9'h0e0,
                           9'h0e8, 9'h0f0, 9'h0f8, 9'h100};
    return t[i];
  endfunction

  function automatic int oct_distance(input int dx, input int dy);
    int ax, ay, lo, hi, v;
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    lo = ax < ay ? ax : ay;
    hi = ax < ay ? ay : ax;
    v = hi * 1007 + lo * 441;
    if (hi < lo * 16) v -= hi * 40;
    return (v + 512) >>> 10;
  endfunction

  task automatic add_light(input int cx, input int cy, input int rad, input int pw);
    int x0, x1, y0, y1, decay, drop, p, sum, idx;
    x0 = cx - rad; x1 = cx + rad; y0 = cy - rad; y1 = cy + rad;
    if (rad == 0) return;
    if (x1 < int'(shade_cfg.left) || y1 < int'(shade_cfg.top) ||
        x0 > int'(shade_cfg.right) || y0 > int'(shade_cfg.bottom)) return;
    if (x0 < int'(shade_cfg.left)) x0 = int'(shade_cfg.left);
    if (x1 > int'(shade_cfg.right)) x1 = int'(shade_cfg.right);
    if (y0 < int'(shade_cfg.top)) y0 = int'(shade_cfg.top);
    if (y1 > int'(shade_cfg.bottom)) y1 = int'(shade_cfg.bottom);
    decay = (pw * 256) / rad;
    for (int ty = y0; ty <= y1; ty++) begin
      if (ty < 0 || ty >= MH) continue;
      for (int tx = x0; tx <= x1; tx++) begin
        if (tx < 0 || tx >= MW) continue;
        drop = (oct_distance(tx - cx, ty - cy) * decay) >>> 8;
        p = drop >= pw ? 0 : pw - drop;
        idx = tx + MW * ty;
        sum = int'(lmap[idx]) + int'(lvl(p[3:0]));
        lmap[idx] = sum > 256 ? 9'h100 : sum[8:0];
      end
    end
  endtask

  function automatic logic [15:0] shade_pixel(input int x, input int y, input logic [15:0] c);
    logic [31:0] cl, tc;
    if (!shade_cfg.enable) return c;
    if (x < int'(shade_cfg.left) || x > int'(shade_cfg.right) ||
        y < int'(shade_cfg.top) || y > int'(shade_cfg.bottom)) return c;
    if (x < 0 || x >= MW || y < 0 || y >= MH) return c;
    cl = 32'(lmap[x + MW * y]);
    tc = (((32'(c) & 32'hf800) * cl) >> 8) & 32'hf800;
    tc |= (((32'(c) & 32'h07e0) * cl) >> 8) & 32'h07e0;
    tc |= (((32'(c) & 32'h001f) * cl) >> 8) & 32'h001f;
    return tc[15:0];
  endfunction

  // update the map for one accepted item; returns 1 if a pixel is expected
  task automatic apply_item(input cmd_t c, output bit has_px, output logic [15:0] px);
    has_px = 1'b0;
    px = '0;
    case (c.kind)
      KIND_CLEAR: foreach (lmap[i]) lmap[i] = lvl(c.fill_level);
      KIND_LIGHT: add_light(int'($signed(c.pos_x)), int'($signed(c.pos_y)),
                            int'(c.radius), int'(c.power));
      KIND_SHADE: begin
        has_px = 1'b1;
        px = shade_pixel(int'($signed(c.pos_x)), int'($signed(c.pos_y)), c.pixel_color);
      end
      default: ;
    endcase
  endtask

  // input idles for the length of the gap
  task automatic gap(input int lo_pct);
    int n;
    if ($urandom_range(99) < lo_pct) return;
    n = ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(3, 1);
    in_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // one item through the input channel; valid stays up for a following item
  task automatic send_item(input cmd_t c, input bit typed, input logic [15:0] want);
    bit h;
    logic [15:0] px;
    kind <= c.kind; pos_x <= c.pos_x; pos_y <= c.pos_y; radius <= c.radius;
    power <= c.power; fill_level <= c.fill_level; pixel_color <= c.pixel_color;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    apply_item(c, h, px);
    if (h) begin
      if (typed && px !== want) begin
        $display("%0t table row disagrees: expected %h got %h", $time, want, px);
        n_err++;
      end
      pixel_q.push_back(typed ? want : px);
    end
    @(negedge clk);
  endtask

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] v);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= v; penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_ENABLE: shade_cfg.enable = v[0];
      REG_LEFT:   shade_cfg.left   = v[6:0];
      REG_TOP:    shade_cfg.top    = v[5:0];
      REG_RIGHT:  shade_cfg.right  = v[6:0];
      REG_BOTTOM: shade_cfg.bottom = v[5:0];
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // wait for outstanding pixels, then for up to three clear or light items
  // still running, each over at most the entries of a 128x64 window
  task automatic drain;
    in_valid <= 1'b0;
    while (pixel_q.size() != 0) @(negedge clk);
    repeat (3 * (3 * 128 * MH + 16) + MW * MH + 200) @(negedge clk);
  endtask

  task automatic set_clip(input int l, input int t, input int r, input int b, input bit en);
    reg_write(REG_LEFT, l);
    reg_write(REG_TOP, t);
    reg_write(REG_RIGHT, r);
    reg_write(REG_BOTTOM, b);
    reg_write(REG_ENABLE, 32'(en));
  endtask

  function automatic cmd_t mk(input logic [1:0] k, input int x, input int y, input int r,
                              input int p, input int f, input int col);
    cmd_t c;
    c.kind = k; c.pos_x = 9'(x); c.pos_y = 9'(y); c.radius = 8'(r); c.power = 4'(p);
    c.fill_level = 4'(f); c.pixel_color = 16'(col);
    return c;
  endfunction

  function automatic cmd_t rand_item;
    cmd_t c;
    int sel;
    c = mk(KIND_SHADE, 0, 0, 0, 0, 0, 0);
    {c.radius, c.power, c.fill_level, c.pixel_color} = $urandom();
    sel = $urandom_range(99);
    if (sel < 2) c.kind = KIND_CLEAR;
    else if (sel < 12) c.kind = KIND_LIGHT;
    else if (sel < 14) c.kind = 2'd3;
    // keep lights small mostly; positions mostly on the map
    if (c.kind == KIND_LIGHT && $urandom_range(15) != 0) c.radius = 8'($urandom_range(12));
    if ($urandom_range(9) == 0) begin
      c.pos_x = 9'($urandom()); c.pos_y = 9'($urandom());
    end else begin
      c.pos_x = 9'($urandom_range(MW + 3) - 2); c.pos_y = 9'($urandom_range(MH + 3) - 2);
    end
    return c;
  endfunction

  // result side: random stalls and the comparison
  initial begin
    logic [15:0] exp_px;
    out_ready = 1'b0;
    n_err = 0;
    forever begin
      @(negedge clk);
      out_ready <= ($urandom_range(3) != 0) || ($urandom_range(19) == 0);
      @(posedge clk);
      if (out_valid && out_ready) begin
        if (pixel_q.size() == 0) begin
          $display("%0t unexpected pixel: expected none got %h", $time, shaded_color);
          n_err++;
        end else begin
          exp_px = pixel_q.pop_front();
          if (shaded_color !== exp_px) begin
            $display("%0t shaded_color: expected %h got %h", $time, exp_px, shaded_color);
            n_err++;
          end
        end
      end
    end
  end

  // watchdog on cycles with no item accepted, no pixel taken and no register access
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || psel) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_CYCLES && !stim_done) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    row_t rows [$];
    stim_done = 1'b0;
    rst = 1'b1;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    in_valid = 0; kind = '0; pos_x = '0; pos_y = '0; radius = '0; power = '0;
    fill_level = '0; pixel_color = '0;
    foreach (lmap[i]) lmap[i] = '0;
    shade_cfg = '{enable: 1'b1, left: 7'd0, top: 6'd0, right: 7'd79, bottom: 6'd63};
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // directed table
    rows.push_back('{mk(KIND_SHADE, 5, 5, 0, 0, 0, 16'hffff), 1, 16'h0000});
    rows.push_back('{mk(KIND_CLEAR, 0, 0, 0, 0, 15, 0), 0, NO_CHECK});
    rows.push_back('{mk(KIND_SHADE, 0, 0, 0, 0, 0, 16'hffff), 1, 16'hffff});
    rows.push_back('{mk(KIND_SHADE, 79, 63, 0, 0, 0, 16'h1234), 1, 16'h1234});
    rows.push_back('{mk(KIND_SHADE, -256, 255, 0, 0, 0, 16'hbeef), 1, 16'hbeef});
    rows.push_back('{mk(KIND_SHADE, 80, 0, 0, 0, 0, 16'hbeef), 1, 16'hbeef});
    rows.push_back('{mk(KIND_CLEAR, 0, 0, 0, 0, 0, 0), 0, NO_CHECK});
    rows.push_back('{mk(KIND_SHADE, 10, 10, 0, 0, 0, 16'hffff), 1, 16'h0000});
    rows.push_back('{mk(KIND_LIGHT, 40, 30, 0, 15, 0, 0), 0, NO_CHECK});
    rows.push_back('{mk(KIND_LIGHT, 40, 30, 6, 15, 0, 0), 0, NO_CHECK});
    rows.push_back('{mk(KIND_LIGHT, 40, 30, 3, 9, 0, 0), 0, NO_CHECK});
    rows.push_back('{mk(KIND_SHADE, 40, 30, 0, 0, 0, 16'hffff), 0, NO_CHECK});
    rows.push_back('{mk(KIND_SHADE, 42, 31, 0, 0, 0, 16'h8410), 0, NO_CHECK});
    rows.push_back('{mk(KIND_LIGHT, -256, -256, 255, 15, 0, 0), 0, NO_CHECK});
    rows.push_back('{mk(KIND_LIGHT, 255, 255, 255, 1, 0, 0), 0, NO_CHECK});
    rows.push_back('{mk(KIND_LIGHT, 0, 0, 4, 15, 0, 0), 0, NO_CHECK});
    rows.push_back('{mk(2'd3, 1, 1, 1, 1, 1, 16'h5555), 0, NO_CHECK});
    rows.push_back('{mk(KIND_SHADE, 0, 0, 0, 0, 0, 16'h07e0), 0, NO_CHECK});
    rows.push_back('{mk(KIND_SHADE, 2, 1, 0, 0, 0, 16'hf81f), 0, NO_CHECK});
    foreach (rows[i]) begin
      send_item(rows[i].c, rows[i].typed, rows[i].want);
      gap(60);
    end
    drain();

    // random phases across clip settings, extremes included
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_clip(0, 0, 79, 63, 1);
        1: set_clip(10, 5, 50, 40, 1);
        2: set_clip(0, 0, 127, 63, 1);
        3: set_clip(60, 40, 20, 10, 1);
        4: set_clip(79, 63, 79, 63, 1);
        5: set_clip(0, 0, 79, 63, 0);
        6: set_clip(127, 0, 0, 63, 1);
        default: set_clip($urandom_range(40), $urandom_range(30),
                          $urandom_range(127, 40), $urandom_range(63, 30), 1);
      endcase
      for (int n = 0; n < 135; n++) begin
        send_item(rand_item(), 0, NO_CHECK);
        if ($urandom_range(3) != 0) gap(50);
      end
      drain();
    end

    stim_done = 1'b1;
    if (n_err == 0 && pixel_q.size() == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/rlms_pkg.sv
rtl/core/rlms_ram.sv
rtl/core/rlms_front.sv
rtl/core/rlms_back.sv
rtl/core/radial_light_map_shader.sv
tb/sv/radial_light_map_shader_tb.sv
